/* sv/weekly_schedule_heater_timer_unit_macros.svh */
// assertion helpers for the heater timer unit module
// both sample on the rising edge of clock and are off while reset is high
`ifndef WEEKLY_SCHEDULE_HEATER_TIMER_UNIT_MACROS_SVH
`define WEEKLY_SCHEDULE_HEATER_TIMER_UNIT_MACROS_SVH

// same-cycle implication
`define WHTU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WHTU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/whtu_pkg.sv */
package whtu_pkg;

   // schedule entries held in configuration registers
   localparam int CfgEntries        = 6;
   localparam int NumEntriesDefault = 6;

   localparam logic [1:0]  MaxBoostRequests = 2'd3;
   localparam logic [15:0] HistForce        = 16'hFE00;
   localparam logic [15:0] HistPress        = 16'hFF00;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;
   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 40;

   localparam logic [2:0]  DayReset           = 3'd1;
   localparam logic [15:0] BoostDurationReset = 16'd1800;
   localparam logic [15:0] BoostStepReset     = 16'd900;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_BOOST  = 2'd1,
      ACT_TOGGLE = 2'd2,
      ACT_BUTTON = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      REG_ENTRY_0        = 3'd0,
      REG_ENTRY_1        = 3'd1,
      REG_ENTRY_2        = 3'd2,
      REG_ENTRY_3        = 3'd3,
      REG_ENTRY_4        = 3'd4,
      REG_ENTRY_5        = 3'd5,
      REG_BOOST_DURATION = 3'd6,
      REG_BOOST_STEP     = 3'd7
   } reg_index_type;

   // packed exactly as the register: days 28:22, on 21:11, off 10:0
   typedef struct packed {
      logic [6:0]  days;
      logic [10:0] on_minute;
      logic [10:0] off_minute;
   } entry_type;

   typedef struct packed {
      logic [2:0]  day;
      logic [10:0] minute;
   } clock_now_type;

   localparam entry_type EntryReset0 = entry_type'(29'd533598598);
   localparam entry_type EntryResetN = entry_type'(29'd860580);

endpackage

/* sv/whtu_window_hit.sv */
module whtu_window_hit (
   input  whtu_pkg::entry_type     entry,
   input  whtu_pkg::clock_now_type now,
   output logic                    hit
);

   logic [7:0] mask_ext;
   logic       day_ok;
   logic       in_window;

   // bit 0 stands for weekday zero, which never matches
   assign mask_ext = {entry.days, 1'b0};
   assign day_ok   = mask_ext[now.day];

   always_comb begin
      if (entry.on_minute == entry.off_minute) begin
         in_window = 1'b0;
      end else if (entry.on_minute < entry.off_minute) begin
         in_window = (now.minute >= entry.on_minute) && (now.minute < entry.off_minute);
      end else begin
         // wraps past midnight
         in_window = (now.minute >= entry.on_minute) || (now.minute < entry.off_minute);
      end
   end

   assign hit = day_ok && in_window;

endmodule

/* sv/weekly_schedule_heater_timer_unit.sv */
// a request transfer passes the input register, then the result register, before its response goes out
// throughput: one request per cycle, back to back, as long as rsp_tready keeps up
// all per-item work is one pass through the window compares and boost logic
// reset (synchronous, active high) clears the pipeline valids, loads register defaults
// and restores day 1, minute 0, enable off, no boost, report pending
module weekly_schedule_heater_timer_unit #(
   parameter int NUM_ENTRIES = whtu_pkg::NumEntriesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: weekday[2:0], minute_of_day[13:3], button_level[14], zero[15]
   input  logic [whtu_pkg::ReqDataWidth-1:0]    req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]                           req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: heating_on[0], heating_enabled[1], boost_left[17:2], boost_presses[19:18],
   //        report_due[20], day_now[23:21], minute_now[34:24], zero[39:35]
   output logic [whtu_pkg::RspDataWidth-1:0]    rsp_tdata,
   // configuration port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [whtu_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [whtu_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [whtu_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   `include "weekly_schedule_heater_timer_unit_macros.svh"

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   whtu_pkg::entry_type    entry_ff [whtu_pkg::CfgEntries];
   logic [15:0]            boost_duration_ff;
   logic [15:0]            boost_step_ff;
   whtu_pkg::reg_index_type csr_index;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = whtu_pkg::reg_index_type'(csr_paddr[whtu_pkg::CsrAddrWidth-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff[0] <= whtu_pkg::EntryReset0;
         for (int i = 1; i < whtu_pkg::CfgEntries; i++) begin
            entry_ff[i[2:0]] <= whtu_pkg::EntryResetN;
         end
         boost_duration_ff <= whtu_pkg::BoostDurationReset;
         boost_step_ff     <= whtu_pkg::BoostStepReset;
      end else if (csr_write) begin
         case (csr_index)
            whtu_pkg::REG_BOOST_DURATION: boost_duration_ff <= csr_pwdata[15:0];
            whtu_pkg::REG_BOOST_STEP:     boost_step_ff     <= csr_pwdata[15:0];
            default:                      entry_ff[csr_index] <= csr_pwdata[28:0];
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         whtu_pkg::REG_BOOST_DURATION: csr_prdata = {16'd0, boost_duration_ff};
         whtu_pkg::REG_BOOST_STEP:     csr_prdata = {16'd0, boost_step_ff};
         default:                      csr_prdata = {3'd0, entry_ff[csr_index]};
      endcase
   end

   // ------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------
   logic                 in_valid_ff;
   whtu_pkg::action_type in_action_ff;
   logic [2:0]           in_weekday_ff;
   logic [10:0]          in_minute_ff;
   logic                 in_button_ff;
   logic                 rsp_valid_ff;
   logic                 advance;

   // item in the input register moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_action_ff  <= whtu_pkg::action_type'(req_tuser);
         in_weekday_ff <= req_tdata[2:0];
         in_minute_ff  <= req_tdata[13:3];
         in_button_ff  <= req_tdata[14];
      end
   end

   // ------------------------------------------------------------------
   // controller state
   // ------------------------------------------------------------------
   logic [2:0]  day_ff,      day_in;
   logic [10:0] minute_ff,   minute_in;
   logic        enable_ff,   enable_in;
   logic        demand_ff,   demand_in;
   logic [15:0] countdown_ff, countdown_in;
   logic [1:0]  presses_ff,  presses_in;
   logic        report_ff,   report_in;
   logic [15:0] history_ff,  history_in;
   logic        report_out;

   // a tick loads the clock only when the minute moves
   logic                    minute_changed;
   whtu_pkg::clock_now_type now_sel;
   logic [NUM_ENTRIES-1:0]  hits;
   logic                    any_hit;
   logic                    countdown_zero;
   logic [16:0]             boost_sum;
   logic [15:0]             boost_sat;

   assign minute_changed = (in_minute_ff != minute_ff);
   assign now_sel.day    = minute_changed ? in_weekday_ff : day_ff;
   assign now_sel.minute = minute_changed ? in_minute_ff  : minute_ff;

   // one window compare per slot backed by a configuration register, all in parallel
   for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_slot
      if (g < whtu_pkg::CfgEntries) begin : g_used
         whtu_window_hit u_window_hit (
            .entry (entry_ff[g]),
            .now   (now_sel),
            .hit   (hits[g])
         );
      end else begin : g_empty
         // slots past the register file hold zero and never match
         assign hits[g] = 1'b0;
      end
   end

   assign any_hit        = |hits;
   assign countdown_zero = (countdown_ff == 16'd0);
   assign boost_sum      = {1'b0, countdown_ff} + {1'b0, boost_step_ff};
   assign boost_sat      = boost_sum[16] ? 16'hFFFF : boost_sum[15:0];

   always_comb begin
      day_in       = day_ff;
      minute_in    = minute_ff;
      enable_in    = enable_ff;
      demand_in    = demand_ff;
      countdown_in = countdown_ff;
      presses_in   = presses_ff;
      report_in    = report_ff;
      history_in   = history_ff;
      report_out   = 1'b0;
      case (in_action_ff)
         whtu_pkg::ACT_TICK: begin
            day_in    = now_sel.day;
            minute_in = now_sel.minute;
            demand_in = enable_ff && (any_hit || !countdown_zero);
            if (enable_ff && !countdown_zero) begin
               countdown_in = countdown_ff - 16'd1;
            end
            // flag goes out with this tick, then clears
            report_out = report_ff || minute_changed || (enable_ff && !countdown_zero);
            report_in  = 1'b0;
         end
         whtu_pkg::ACT_BOOST: begin
            if (countdown_zero) begin
               presses_in   = 2'd1;
               countdown_in = boost_duration_ff;
               enable_in    = 1'b1;
            end else if (presses_ff < whtu_pkg::MaxBoostRequests) begin
               countdown_in = boost_sat;
               presses_in   = presses_ff + 2'd1;
            end else begin
               // one request too many cancels the boost
               countdown_in = 16'd0;
               presses_in   = 2'd0;
            end
            report_in = 1'b1;
         end
         whtu_pkg::ACT_TOGGLE: begin
            enable_in = !enable_ff;
            report_in = 1'b1;
         end
         whtu_pkg::ACT_BUTTON: begin
            // debounce: a clean press edge leaves exactly the press pattern
            history_in = {history_ff[14:0], in_button_ff} | whtu_pkg::HistForce;
            if (history_in == whtu_pkg::HistPress) begin
               if (countdown_zero) begin
                  presses_in   = 2'd1;
                  countdown_in = boost_duration_ff;
                  enable_in    = 1'b1;
               end else begin
                  countdown_in = 16'd0;
                  presses_in   = 2'd0;
               end
               report_in = 1'b1;
            end
         end
         default: begin
            report_out = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff       <= whtu_pkg::DayReset;
         minute_ff    <= 11'd0;
         enable_ff    <= 1'b0;
         demand_ff    <= 1'b0;
         countdown_ff <= 16'd0;
         presses_ff   <= 2'd0;
         report_ff    <= 1'b1;
         history_ff   <= 16'd0;
      end else if (advance) begin
         day_ff       <= day_in;
         minute_ff    <= minute_in;
         enable_ff    <= enable_in;
         demand_ff    <= demand_in;
         countdown_ff <= countdown_in;
         presses_ff   <= presses_in;
         report_ff    <= report_in;
         history_ff   <= history_in;
      end
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   logic                              rsp_valid_in;
   logic [whtu_pkg::RspDataWidth-1:0] rsp_data_ff;
   logic [whtu_pkg::RspDataWidth-1:0] rsp_data_in;

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = {5'd0, minute_in, day_in, report_out, presses_in, countdown_in,
                          enable_in, demand_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   logic presses_ok;   // press count within its limit
   logic tick_step;    // tick leaving the input register
   logic other_step;   // any other action leaving the input register
   logic in_stalled;   // input register held by a busy result register

   assign presses_ok = (presses_ff <= whtu_pkg::MaxBoostRequests);
   assign tick_step  = advance && (in_action_ff == whtu_pkg::ACT_TICK);
   assign other_step = advance && (in_action_ff != whtu_pkg::ACT_TICK);
   assign in_stalled = in_valid_ff && !advance;

   `WHTU_ASSERT_NOW(a_presses_limit, 1'b1, presses_ok, "boost press count above limit")
   `WHTU_ASSERT_NOW(a_countdown_has_press, !countdown_zero, |presses_ff, "boost with no press")
   `WHTU_ASSERT_NEXT(a_tick_clears_report, tick_step, !report_ff, "report not cleared")
   `WHTU_ASSERT_NEXT(a_demand_on_tick_only, other_step, $stable(demand_ff), "demand off tick")
   `WHTU_ASSERT_NEXT(a_stalled_item_kept, in_stalled, in_valid_ff, "stalled request lost")

endmodule
